/* hdl/cgms_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cgms_pkg
// Shared register indexes and the control bundle passed down the cell row.
// ---------------------------------------------------------------------------
package cgms_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 2;
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_SUBTRAHEND = 2'd1,
    REG_MODULUS    = 2'd2
  } reg_idx_t;

  // Per-beat control that rides alongside the datapath
  typedef struct packed {
    logic valid;
    logic last;
    logic above;
  } ctl_t;

endpackage
`default_nettype wire

/* hdl/cgms_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cgms_cell
// One restoring remainder step: shifts in one coefficient bit and
// subtracts the modulus when the partial remainder reaches it.
// ---------------------------------------------------------------------------
module cgms_cell
  import cgms_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64,
  parameter int unsigned BIT_IDX    = 0
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [DATA_WIDTH-1:0] modulus,
  input  ctl_t                  ctl_i,
  input  wire  [DATA_WIDTH-1:0] rem_i,
  input  wire  [DATA_WIDTH-1:0] op_i,
  output ctl_t                  ctl_o,
  output logic [DATA_WIDTH-1:0] rem_o,
  output logic [DATA_WIDTH-1:0] op_o
);

  localparam int unsigned OpBit = DATA_WIDTH - 1 - BIT_IDX;

  ctl_t                  ctl_r;
  logic [DATA_WIDTH-1:0] rem_r, rem_nxt;
  logic [DATA_WIDTH-1:0] op_r;
  logic [DATA_WIDTH:0]   shifted;

  // compare and conditional subtract; the difference is below the modulus,
  // so the low bits carry it exactly
  always_comb begin
    shifted = {rem_i, op_i[OpBit]};
    if (shifted >= {1'b0, modulus}) begin
      rem_nxt = shifted[DATA_WIDTH-1:0] - modulus;
    end else begin
      rem_nxt = shifted[DATA_WIDTH-1:0];
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    op_r  <= op_i;
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign op_o  = op_r;

  a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.valid |=> ctl_o.valid) else $error("cell dropped a beat");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_i.valid |=> !ctl_o.valid) else $error("cell invented a beat");

endmodule
`default_nettype wire

/* hdl/cgms_finish.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cgms_finish
// Final stage: gated wrapping subtraction and setting check, registered.
// ---------------------------------------------------------------------------
module cgms_finish
  import cgms_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [DATA_WIDTH-1:0] subtrahend,
  input  wire  [DATA_WIDTH-1:0] modulus,
  input  ctl_t                  ctl_i,
  input  wire  [DATA_WIDTH-1:0] red_i,
  output logic                  valid_o,
  output logic [DATA_WIDTH-1:0] result_o,
  output logic                  last_o,
  output logic                  fault_o
);

  logic                  valid_r;
  logic [DATA_WIDTH-1:0] result_r, result_nxt;
  logic                  last_r;
  logic                  fault_r;

  // wrap by the modulus when the reduced value is below the subtrahend
  always_comb begin
    if (!ctl_i.above) begin
      result_nxt = red_i;
    end else if (red_i < subtrahend) begin
      result_nxt = red_i + modulus - subtrahend;
    end else begin
      result_nxt = red_i - subtrahend;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
    last_r   <= ctl_i.last;
    fault_r  <= (subtrahend >= modulus);
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;
  assign last_o   = last_r;
  assign fault_o  = fault_r;

  a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_i.valid |=> valid_o) else $error("final stage dropped a beat");
  a_beat_none: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl_i.valid |=> !valid_o) else $error("final stage invented a beat");

endmodule
`default_nettype wire

/* hdl/compare_gated_modular_subtract.sv */
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// compare_gated_modular_subtract
// Reduces each coefficient modulo a configured modulus and, when the raw
// coefficient is above the threshold, subtracts the subtrahend modulo it.
// ---------------------------------------------------------------------------
// One coefficient is taken every cycle (busy stays low) and its result
// appears on out_valid after it has passed the row of DATA_WIDTH remainder
// cells, one coefficient bit per cell, and then one output stage. Results
// cannot be held off. Configuration may be written only while no beat is in
// flight.
module compare_gated_modular_subtract
  import cgms_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire  [CfgIdxWidth-1:0] cfg_index,
  input  wire  [DATA_WIDTH-1:0] cfg_data,
  input  wire                   start,
  output logic                  busy,
  input  wire  [DATA_WIDTH-1:0] in_coefficient,
  input  wire                   in_last_in,
  output logic                  out_valid,
  output logic [DATA_WIDTH-1:0] out_result,
  output logic                  out_last_out,
  output logic                  out_setting_fault
);

  logic [DATA_WIDTH-1:0] threshold_r, subtrahend_r, modulus_r;

  ctl_t                  ctl   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] opnd  [0:DATA_WIDTH];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= '0;
      subtrahend_r <= '0;
      modulus_r    <= {{(DATA_WIDTH-1){1'b0}}, 1'b1};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:  threshold_r  <= cfg_data;
        REG_SUBTRAHEND: subtrahend_r <= cfg_data;
        REG_MODULUS:    modulus_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // entry: threshold compare on the raw coefficient
  always_comb begin
    ctl[0].valid = start;
    ctl[0].last  = in_last_in;
    ctl[0].above = (in_coefficient > threshold_r);
  end
  assign rem[0]  = '0;
  assign opnd[0] = in_coefficient;

  // remainder cell row
  for (genvar g = 0; g < DATA_WIDTH; g++) begin : g_cell
    cgms_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .BIT_IDX    (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .modulus (modulus_r),
      .ctl_i   (ctl[g]),
      .rem_i   (rem[g]),
      .op_i    (opnd[g]),
      .ctl_o   (ctl[g+1]),
      .rem_o   (rem[g+1]),
      .op_o    (opnd[g+1])
    );
  end

  cgms_finish #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .subtrahend (subtrahend_r),
    .modulus    (modulus_r),
    .ctl_i      (ctl[DATA_WIDTH]),
    .red_i      (rem[DATA_WIDTH]),
    .valid_o    (out_valid),
    .result_o   (out_result),
    .last_o     (out_last_out),
    .fault_o    (out_setting_fault)
  );

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("beat out right after reset");
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !busy) else $error("busy raised");

endmodule
`default_nettype wire

/* tb/compare_gated_modular_subtract_test.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// compare_gated_modular_subtract_test
// Drives coefficients through the threshold-gated modular subtractor under
// several register settings, predicts every result and checks each output
// beat in order against the expected queue.
// ---------------------------------------------------------------------------
module compare_gated_modular_subtract_test;
  import cgms_pkg::*;

  localparam int unsigned W = 64;
  localparam int unsigned LATENCY = W + 1;

  typedef struct {
    logic [W-1:0] result;
    logic         last;
    logic         fault;
  } beat_t;

  // Directed rows: coefficient, last, expected result where known (chk)
  typedef struct {
    logic [W-1:0] coef;
    logic         last;
    logic         chk;
    logic [W-1:0] res;
  } row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  reg_idx_t     cfg_index = REG_THRESHOLD;
  logic [W-1:0] cfg_data = '0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] in_coefficient = '0;
  logic         in_last_in = 1'b0;
  logic         out_valid;
  logic [W-1:0] out_result;
  logic         out_last_out;
  logic         out_setting_fault;

  logic [W-1:0] thr_q = '0, sub_q = '0, mod_q = 64'd1;
  beat_t        pending_q[$];
  int           fail_cnt = 0;

  compare_gated_modular_subtract #(.DATA_WIDTH(W)) u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .start, .busy,
    .in_coefficient, .in_last_in, .out_valid, .out_result, .out_last_out,
    .out_setting_fault
  );

  always #10 clk = ~clk;

  // Hard stop well beyond the slowest legal run
  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic beat_t gated_sub(logic [W-1:0] c, logic l);
    beat_t b;
    logic [W-1:0] red, add;
    red = (mod_q != 0) ? c % mod_q : c;
    add = (red < sub_q) ? mod_q : '0;
    add = add - sub_q;
    if (!(c > thr_q)) add = '0;
    b.result = red + add;
    b.last = l;
    b.fault = (sub_q >= mod_q);
    return b;
  endfunction

  // Output checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        $error("unexpected beat: result %h", out_result);
        fail_cnt++;
      end else begin
        beat_t e;
        e = pending_q.pop_front();
        if (out_result !== e.result) begin
          $error("result exp %h got %h", e.result, out_result); fail_cnt++;
        end
        if (out_last_out !== e.last) begin
          $error("last_out exp %b got %b", e.last, out_last_out); fail_cnt++;
        end
        if (out_setting_fault !== e.fault) begin
          $error("setting_fault exp %b got %b", e.fault, out_setting_fault);
          fail_cnt++;
        end
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD:  thr_q = val;
      REG_SUBTRAHEND: sub_q = val;
      REG_MODULUS:    mod_q = val;
      default: ;
    endcase
  endtask

  // Wait for all beats to drain plus the pipeline depth
  task automatic drain;
    int n;
    n = 0;
    while (pending_q.size() != 0 && n < 100000) begin
      @(negedge clk); n++;
    end
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  // One beat on the input side; start stays high across back-to-back beats
  task automatic send(logic [W-1:0] c, logic l, logic [W-1:0] exp_res, logic chk);
    beat_t b;
    start <= 1'b1; in_coefficient <= c; in_last_in <= l;
    @(posedge clk);
    while (busy) @(posedge clk);
    b = gated_sub(c, l);
    if (chk) b.result = exp_res;
    pending_q.push_back(b);
    @(negedge clk);
  endtask

  task automatic idle_gap;
    int g;
    start <= 1'b0;
    g = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    repeat (g) @(negedge clk);
  endtask

  function automatic logic [W-1:0] rnd64;
    return {$urandom(), $urandom()};
  endfunction

  // Coefficients biased toward the threshold, small multiples of modulus and values near all-zeros or all-ones
  function automatic logic [W-1:0] pick_coef;
    case ($urandom_range(0, 5))
      0: return thr_q + $urandom_range(0, 2) - 1;
      1: return mod_q * $urandom_range(0, 4) + $urandom_range(0, 2) - 1;
      2: return (($urandom_range(0, 1) != 0) ? {W{1'b1}} : {W{1'b0}}) ^
                W'($urandom_range(0, 3));
      default: return rnd64();
    endcase
  endfunction

  localparam logic [W-1:0] MAXV = '1;

  // Directed rows under reset registers (thr 0, sub 0, mod 1): result is 0
  row_t rst_rows[] = '{
    '{64'd0, 1'b0, 1'b1, 64'd0},
    '{64'd1, 1'b1, 1'b1, 64'd0},
    '{MAXV,  1'b0, 1'b1, 64'd0}
  };

  initial begin
    row_t rows[$];
    int   phase;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rst_rows[i]) send(rst_rows[i].coef, rst_rows[i].last,
                               rst_rows[i].res, rst_rows[i].chk);
    start <= 1'b0;
    drain();

    // Modulus 10, subtrahend 3, threshold 5
    write_reg(REG_MODULUS, 64'd10);
    write_reg(REG_SUBTRAHEND, 64'd3);
    write_reg(REG_THRESHOLD, 64'd5);
    rows = '{
      '{64'd5,  1'b0, 1'b1, 64'd5},   // at threshold: reduce only
      '{64'd6,  1'b0, 1'b1, 64'd3},   // above: 6-3
      '{64'd11, 1'b0, 1'b1, 64'd8},   // wrap: 1+10-3
      '{64'd13, 1'b1, 1'b1, 64'd0},   // exact subtract
      '{MAXV,   1'b0, 1'b0, 64'd0},
      '{64'd0,  1'b1, 1'b1, 64'd0}
    };
    foreach (rows[i]) send(rows[i].coef, rows[i].last, rows[i].res, rows[i].chk);
    start <= 1'b0;
    drain();

    // Subtrahend not below modulus, then zero modulus
    write_reg(REG_SUBTRAHEND, 64'd12);
    rows = '{'{64'd7, 1'b0, 1'b0, 0}, '{64'd20, 1'b1, 1'b0, 0}, '{MAXV, 1'b0, 1'b0, 0}};
    foreach (rows[i]) send(rows[i].coef, rows[i].last, rows[i].res, rows[i].chk);
    start <= 1'b0;
    drain();
    write_reg(REG_MODULUS, 64'd0);
    write_reg(REG_THRESHOLD, MAXV);
    rows = '{'{MAXV, 1'b0, 1'b1, MAXV}, '{64'd3, 1'b1, 1'b1, 64'd3}};
    foreach (rows[i]) send(rows[i].coef, rows[i].last, rows[i].res, rows[i].chk);
    start <= 1'b0;
    drain();
    write_reg(REG_THRESHOLD, 64'd0);
    rows = '{'{MAXV, 1'b0, 1'b0, 0}, '{64'd0, 1'b1, 1'b0, 0}};
    foreach (rows[i]) send(rows[i].coef, rows[i].last, rows[i].res, rows[i].chk);
    start <= 1'b0;
    drain();

    // Random phases, each with fresh register settings
    for (phase = 0; phase < 14; phase++) begin
      logic [W-1:0] m;
      case (phase % 4)
        0: m = MAXV;
        1: m = 64'd1;
        2: m = $urandom_range(2, 1000);
        default: m = rnd64();
      endcase
      write_reg(REG_MODULUS, m);
      if ($urandom_range(0, 7) == 0) write_reg(REG_SUBTRAHEND, m + $urandom_range(0, 2));
      else write_reg(REG_SUBTRAHEND, (m == 0) ? 0 : rnd64() % m);
      case ($urandom_range(0, 3))
        0: write_reg(REG_THRESHOLD, 64'd0);
        1: write_reg(REG_THRESHOLD, MAXV);
        default: write_reg(REG_THRESHOLD, rnd64());
      endcase
      repeat (125) begin
        send(pick_coef(), $urandom_range(0, 1), '0, 1'b0);
        if ($urandom_range(0, 2) == 0) idle_gap();
      end
      start <= 1'b0;
      drain();
    end

    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
